[sv/rrle_pkg.sv]
// Shared types and constants for the run-length RGBE scanline decoder.
// No dependencies; every other file in the block imports this package.
package rrle_pkg;

    localparam int unsigned ColW   = 15;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned LenW   = 7;
    localparam int unsigned CountW = 8;

    localparam logic [ByteW-1:0] HdrMagic = 8'd2;
    localparam logic [ByteW-1:0] LitMax   = 8'd128;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_HDR2  = 3'd2,
        PH_HDR3  = 3'd3,
        PH_COUNT = 3'd4,
        PH_RUN   = 3'd5,
        PH_LIT   = 3'd6,
        PH_DONE  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_SEGMENT   = 2'd0,
        ST_NOT_RLE   = 2'd1,
        ST_BAD_HDR   = 2'd2,
        ST_BAD_COUNT = 2'd3
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [1:0]        plane;
        logic [ColW-1:0]   row;
        logic [ColW-1:0]   start_col;
        logic [LenW-1:0]   seg_length;
        logic [ByteW-1:0]  seg_value;
        logic              image_done;
    } t_result;

    typedef struct packed {
        logic [ColW-1:0] image_width;
        logic [ColW-1:0] image_height;
    } t_cfg;

endpackage

[sv/rrle_if.sv]
// Channel interfaces of the decoder: byte input, segment output, register writes.
// Depends on rrle_pkg for field widths.
interface rrle_byte_if;
    import rrle_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface rrle_seg_if;
    import rrle_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [1:0]       plane;
    logic [ColW-1:0]  row;
    logic [ColW-1:0]  start_col;
    logic [LenW-1:0]  seg_length;
    logic [ByteW-1:0] seg_value;
    logic             image_done;
    modport source (output valid, output status, output plane, output row,
                    output start_col, output seg_length, output seg_value,
                    output image_done, input ready);
    modport sink (input valid, input status, input plane, input row,
                  input start_col, input seg_length, input seg_value,
                  input image_done, output ready);
endinterface

interface rrle_cfg_if;
    import rrle_pkg::*;
    logic            valid;
    logic            ready;
    logic            index;
    logic [ColW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/rrle_in_stage.sv]
// Input register of the decoder: holds one byte beat until the core steps on it.
// Depends on rrle_pkg and rrle_byte_if.
module rrle_in_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    rrle_byte_if.sink              i_in,
    input  logic                   i_free,
    output logic                   o_step,
    output logic [rrle_pkg::ByteW-1:0] o_byte
);
    import rrle_pkg::*;

    logic             r_valid;
    logic [ByteW-1:0] r_byte;

    // the core consumes the held beat whenever the result side has room
    assign o_step     = r_valid && i_free;
    assign o_byte     = r_byte;
    assign i_in.ready = !r_valid || i_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
        end
    end

endmodule

[sv/rrle_core.sv]
// Decode state machine: header check, packet parsing and segment building.
// Depends on rrle_pkg for the phase enum, status codes and result struct.
module rrle_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [rrle_pkg::ByteW-1:0] i_byte,
    input  rrle_pkg::t_cfg             i_cfg,
    output logic                       o_emit,
    output rrle_pkg::t_result          o_result
);
    import rrle_pkg::*;

    t_phase            r_phase, n_phase;
    logic [ByteW-1:0]  r_hdr, n_hdr;
    logic [ColW-1:0]   r_row, n_row;
    logic [1:0]        r_plane, n_plane;
    logic [ColW-1:0]   r_col, n_col;
    logic [CountW-1:0] r_pend, n_pend;
    logic              r_err, n_err;

    logic [ColW-1:0]   left;
    logic [CountW-1:0] count;
    logic [ColW-1:0]   col_adv;
    logic [ColW-1:0]   row_inc;
    logic              plane_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_hdr   <= '0;
            r_row   <= '0;
            r_plane <= '0;
            r_col   <= '0;
            r_pend  <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_row   <= n_row;
            r_plane <= n_plane;
            r_col   <= n_col;
            r_pend  <= n_pend;
            r_err   <= n_err;
        end
    end

    always_comb begin
        left  = (r_col < i_cfg.image_width) ? (i_cfg.image_width - r_col) : '0;
        count = (i_byte > LitMax) ? (i_byte - LitMax) : i_byte;
        if (r_phase == PH_RUN) begin
            col_adv = r_col + ColW'(r_pend);
        end else begin
            col_adv = r_col + ColW'(1);
        end
        row_inc   = r_row + ColW'(1);
        plane_end = (col_adv >= i_cfg.image_width);

        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_row   = r_row;
        n_plane = r_plane;
        n_col   = r_col;
        n_pend  = r_pend;
        n_err   = r_err;

        o_emit              = 1'b0;
        o_result.status     = ST_SEGMENT;
        o_result.plane      = r_plane;
        o_result.row        = r_row;
        o_result.start_col  = r_col;
        o_result.seg_length = '0;
        o_result.seg_value  = i_byte;
        o_result.image_done = 1'b0;

        if (i_step && !r_err && r_phase != PH_DONE) begin
            case (r_phase)
                PH_HDR0: begin
                    n_hdr   = (i_byte != HdrMagic) ? 8'h80 : 8'h00;
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    if (i_byte != HdrMagic) begin
                        n_hdr = r_hdr | 8'h80;
                    end
                    n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    n_hdr   = {r_hdr[7], 7'd0} | i_byte;
                    n_phase = PH_HDR3;
                end
                PH_HDR3: begin
                    if (r_hdr[7]) begin
                        o_emit          = 1'b1;
                        o_result.status = (r_row == '0) ? ST_NOT_RLE : ST_BAD_HDR;
                        n_err           = 1'b1;
                    end else if ({r_hdr[6:0], i_byte} != i_cfg.image_width) begin
                        o_emit          = 1'b1;
                        o_result.status = ST_BAD_HDR;
                        n_err           = 1'b1;
                    end else begin
                        n_plane = '0;
                        n_col   = '0;
                        n_pend  = '0;
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (count == '0 || ColW'(count) > left) begin
                        o_emit          = 1'b1;
                        o_result.status = ST_BAD_COUNT;
                        n_err           = 1'b1;
                    end else begin
                        n_pend  = count;
                        n_phase = (i_byte > LitMax) ? PH_RUN : PH_LIT;
                    end
                end
                PH_RUN, PH_LIT: begin
                    o_emit = 1'b1;
                    n_col  = col_adv;
                    if (r_phase == PH_RUN) begin
                        o_result.seg_length = r_pend[LenW-1:0];
                        n_pend  = '0;
                        n_phase = PH_COUNT;
                    end else begin
                        o_result.seg_length = LenW'(1);
                        // hold in literal phase until the last pending byte
                        if (r_pend > CountW'(1)) begin
                            n_pend = r_pend - CountW'(1);
                        end else begin
                            n_pend  = '0;
                            n_phase = PH_COUNT;
                        end
                    end
                    if (plane_end) begin
                        n_col  = '0;
                        n_pend = '0;
                        if (r_plane != 2'd3) begin
                            n_plane = r_plane + 2'd1;
                            n_phase = PH_COUNT;
                        end else begin
                            n_plane = '0;
                            n_row   = row_inc;
                            if (row_inc == i_cfg.image_height) begin
                                n_phase             = PH_DONE;
                                o_result.image_done = 1'b1;
                            end else begin
                                n_phase = PH_HDR0;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

endmodule

[sv/rrle_out_stage.sv]
// Result register of the decoder: holds one segment beat until the sink takes it.
// Depends on rrle_pkg and rrle_seg_if.
module rrle_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_emit,
    input  rrle_pkg::t_result i_result,
    output logic              o_free,
    rrle_seg_if.source        o_out
);
    import rrle_pkg::*;

    logic    r_valid;
    t_result r_result;

    // room for a new result when empty or when the held beat leaves now
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_step && i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.status     = r_result.status;
    assign o_out.plane      = r_result.plane;
    assign o_out.row        = r_result.row;
    assign o_out.start_col  = r_result.start_col;
    assign o_out.seg_length = r_result.seg_length;
    assign o_out.seg_value  = r_result.seg_value;
    assign o_out.image_done = r_result.image_done;

endmodule

[sv/rgbe_rle_scanline_decoder_top.sv]
// Top level of the run-length RGBE scanline decoder: config registers and stages.
// Depends on rrle_pkg, rrle_if, rrle_in_stage, rrle_core and rrle_out_stage.
//
//   channel  dir  beat carries
//   i_in     in   in_byte: one byte of compressed image data
//   o_out    out  status, plane, row, start_col, seg_length, seg_value, image_done
//   i_cfg    in   index (0 width, 1 height), data: register write
//
// One byte a cycle sustained while the output is not stalled. A byte sits in the
// input register, then one pass of the decode logic updates the state and loads
// the result register. Reset sets width 8, height 1 and waits for a scanline
// header. Output stalls back up into the input register.
module rgbe_rle_scanline_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrle_byte_if.sink  i_in,
    rrle_seg_if.source o_out,
    rrle_cfg_if.sink   i_cfg
);
    import rrle_pkg::*;

    t_cfg             r_cfg;
    logic             free;
    logic             step;
    logic [ByteW-1:0] cur_byte;
    logic             emit;
    t_result          result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= ColW'(8);
            r_cfg.image_height <= ColW'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg.data;
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg.data;
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    rrle_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_free  (free),
        .o_step  (step),
        .o_byte  (cur_byte)
    );

    rrle_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (cur_byte),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    rrle_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_emit   (emit),
        .i_result (result),
        .o_free   (free),
        .o_out    (o_out)
    );

endmodule
